@@ hw/rtl/rdsf_pkg.sv @@
// Shared types and constants for the red dominance strip feature block.
// Used by rdsf_decide and red_dominance_strip_features; no dependencies.
package rdsf_pkg;

	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 4;
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 12;
	localparam int COL_W      = 11;
	localparam int MARGIN_W   = 8;
	localparam int SUM_W      = 30;
	localparam int CNT_W      = 23;
	localparam int HALF_W     = 15;
	localparam int PART_W     = HALF_W + CNT_W;
	localparam int PROD_W     = SUM_W + CNT_W;
	localparam int NUM_SPLITS = 3;
	localparam int NUM_STRIPS = 3;
	localparam int NUM_ACC    = NUM_SPLITS * NUM_STRIPS;
	localparam int ACC_IDX_W  = 4;

	typedef logic [DIM_W-1:0]    dim_t;
	typedef logic [COL_W-1:0]    col_t;
	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [1:0]          code_t;
	typedef logic [1:0]          reg_idx_t;

	localparam dim_t MAX_WIDTH  = 12'd2048;
	localparam dim_t MAX_HEIGHT = 12'd2048;
	localparam dim_t STEP_CAP   = 12'd20;
	localparam int   STEP_SHIFT = 3;

	localparam dim_t          RST_WIDTH     = 12'd640;
	localparam dim_t          RST_HEIGHT    = 12'd480;
	localparam logic [7:0]    RST_MARGIN    = 8'd20;
	localparam cnt_t          RST_MIN_COUNT = 23'd10;

	localparam reg_idx_t REG_WIDTH     = 2'd0;
	localparam reg_idx_t REG_HEIGHT    = 2'd1;
	localparam reg_idx_t REG_MARGIN    = 2'd2;
	localparam reg_idx_t REG_MIN_COUNT = 2'd3;

	localparam int STRIP_LEFT  = 0;
	localparam int STRIP_MID   = 1;
	localparam int STRIP_RIGHT = 2;

	localparam code_t CODE_NONE  = 2'd0;
	localparam code_t CODE_LEFT  = 2'd1;
	localparam code_t CODE_MID   = 2'd2;
	localparam code_t CODE_RIGHT = 2'd3;

endpackage

@@ hw/rtl/rdsf_decide.sv @@
// End-of-frame decision engine: takes the frame's strip sums and counts and
// compares strip means exactly by cross multiplication. Depends on rdsf_pkg.
module rdsf_decide (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  rdsf_pkg::sum_t                sums [rdsf_pkg::NUM_ACC],
	input  rdsf_pkg::cnt_t                counts [rdsf_pkg::NUM_ACC],
	input  rdsf_pkg::cnt_t                min_count,
	output logic                          busy,
	output logic                          res_valid,
	input  logic                          res_ready,
	output rdsf_pkg::code_t               narrow_split_code,
	output rdsf_pkg::code_t               medium_split_code,
	output rdsf_pkg::code_t               wide_split_code
);
	import rdsf_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_MULL = 3'd2;
	localparam logic [2:0] ST_MULH = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_CMP  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]              state_q;
	logic [1:0]              spl_q;
	logic [1:0]              pair_q;
	sum_t                    num_q [NUM_ACC];
	cnt_t                    den_q [NUM_ACC];
	logic [PART_W-1:0]       part_al_q, part_bl_q, part_ah_q, part_bh_q;
	logic [PROD_W-1:0]       prod_a_q, prod_b_q;
	logic [NUM_SPLITS-1:0][2:0] gt_q, lt_q;
	logic [ACC_IDX_W-1:0]    idx_a, idx_b;
	sum_t                    num_a, num_b;
	cnt_t                    den_a, den_b;
	code_t                   code_c [NUM_SPLITS];
	logic                    deliver;

	// Pair order per split: left/middle, left/right, middle/right.
	always_comb begin
		idx_a = ACC_IDX_W'(spl_q) * ACC_IDX_W'(NUM_STRIPS)
			+ ((pair_q == 2'd2) ? ACC_IDX_W'(STRIP_MID) : ACC_IDX_W'(STRIP_LEFT));
		idx_b = ACC_IDX_W'(spl_q) * ACC_IDX_W'(NUM_STRIPS)
			+ ((pair_q == 2'd0) ? ACC_IDX_W'(STRIP_MID) : ACC_IDX_W'(STRIP_RIGHT));
		num_a = num_q[idx_a];
		num_b = num_q[idx_b];
		den_a = den_q[idx_a];
		den_b = den_q[idx_b];
	end

	always_comb begin
		for (int k = 0; k < NUM_SPLITS; k++) begin
			if (gt_q[k][0] && gt_q[k][1]) begin
				code_c[k] = CODE_LEFT;
			end else if (lt_q[k][0] && gt_q[k][2]) begin
				code_c[k] = CODE_MID;
			end else if (lt_q[k][2] && lt_q[k][1]) begin
				code_c[k] = CODE_RIGHT;
			end else begin
				code_c[k] = CODE_NONE;
			end
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign deliver = (state_q == ST_DONE) && (!res_valid || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			spl_q     <= '0;
			pair_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			if (deliver) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					spl_q   <= '0;
					pair_q  <= '0;
					state_q <= ST_MULL;
				end
				ST_MULL: state_q <= ST_MULH;
				ST_MULH: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_CMP;
				ST_CMP: begin
					state_q <= ST_MULL;
					if (pair_q == 2'd2) begin
						pair_q <= '0;
						if (spl_q == 2'(NUM_SPLITS - 1)) begin
							state_q <= ST_DONE;
						end else begin
							spl_q <= spl_q + 2'd1;
						end
					end else begin
						pair_q <= pair_q + 2'd1;
					end
				end
				ST_DONE: begin
					if (deliver) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load && state_q == ST_IDLE) begin
			num_q <= sums;
			den_q <= counts;
		end
		// Replace a strip whose count is too small by the mean 0/1.
		if (state_q == ST_PREP) begin
			for (int i = 0; i < NUM_ACC; i++) begin
				if (den_q[i] <= min_count) begin
					num_q[i] <= '0;
					den_q[i] <= cnt_t'(1);
				end
			end
		end
		if (state_q == ST_MULL) begin
			part_al_q <= PART_W'(num_a[HALF_W-1:0]) * PART_W'(den_b);
			part_bl_q <= PART_W'(num_b[HALF_W-1:0]) * PART_W'(den_a);
		end
		if (state_q == ST_MULH) begin
			part_ah_q <= PART_W'(num_a[SUM_W-1:HALF_W]) * PART_W'(den_b);
			part_bh_q <= PART_W'(num_b[SUM_W-1:HALF_W]) * PART_W'(den_a);
		end
		if (state_q == ST_SUM) begin
			prod_a_q <= {part_ah_q, {HALF_W{1'b0}}} + PROD_W'(part_al_q);
			prod_b_q <= {part_bh_q, {HALF_W{1'b0}}} + PROD_W'(part_bl_q);
		end
		if (state_q == ST_CMP) begin
			gt_q[spl_q][pair_q] <= (prod_a_q > prod_b_q);
			lt_q[spl_q][pair_q] <= (prod_b_q > prod_a_q);
		end
		if (deliver) begin
			narrow_split_code <= code_c[0];
			medium_split_code <= code_c[1];
			wide_split_code   <= code_c[2];
		end
	end

endmodule

@@ hw/rtl/red_dominance_strip_features.sv @@
// Red dominance strip features: accepts one RGB pixel per clock in raster order and,
// after the last pixel of a frame is taken, offers one result item with three
// split codes. Per pixel the work is a registered compare-and-accumulate pass; the
// end-of-frame decision runs in rdsf_decide, which forms 18 cross products from 15x23
// partial products: a PREP setup state, then MULL, MULH, SUM and CMP per strip pair,
// then a DONE handoff state, after the last pixel's accumulate stage. The next frame
// streams in meanwhile; only a frame's last pixel is held off, while the previous
// decision is still running or still waiting to hand its codes to the output register.
module red_dominance_strip_features (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rdsf_pkg::ADDR_W-1:0] paddr,
	input  logic [rdsf_pkg::DATA_W-1:0] pwdata,
	output logic [rdsf_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       pix_valid,
	output logic                       pix_ready,
	input  logic [rdsf_pkg::PIX_W-1:0] red,
	input  logic [rdsf_pkg::PIX_W-1:0] green,
	input  logic [rdsf_pkg::PIX_W-1:0] blue,
	output logic                       res_valid,
	input  logic                       res_ready,
	output rdsf_pkg::code_t            narrow_split_code,
	output rdsf_pkg::code_t            medium_split_code,
	output rdsf_pkg::code_t            wide_split_code
);
	import rdsf_pkg::*;

	dim_t                 width_q, height_q;
	logic [MARGIN_W-1:0]  margin_q;
	cnt_t                 min_count_q;
	reg_idx_t             reg_sel;
	logic                 wr_en, dim_wr;

	dim_t                 w_eff, h_eff, step;
	dim_t                 lo_end_c [NUM_SPLITS];
	dim_t                 mid_end_c [NUM_SPLITS];
	dim_t                 rt_start_c [NUM_SPLITS];
	dim_t                 lo_end_q [NUM_SPLITS];
	dim_t                 mid_end_q [NUM_SPLITS];
	dim_t                 rt_start_q [NUM_SPLITS];

	col_t                 col_q, row_q;
	logic                 col_wrap, is_last, accept, is_red;

	logic                 valid_s1, last_s1, hit_s1;
	logic [PIX_W-1:0]     red_s1;
	col_t                 x_s1;
	dim_t                 x_ext;

	sum_t                 acc_sum_q [NUM_ACC];
	cnt_t                 acc_cnt_q [NUM_ACC];
	sum_t                 sum_nx [NUM_ACC];
	cnt_t                 cnt_nx [NUM_ACC];
	logic                 in_strip [NUM_ACC];
	logic                 dec_busy, dec_load;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign dim_wr  = wr_en && (reg_sel == REG_WIDTH || reg_sel == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= RST_WIDTH;
			height_q    <= RST_HEIGHT;
			margin_q    <= RST_MARGIN;
			min_count_q <= RST_MIN_COUNT;
		end else if (wr_en) begin
			case (reg_sel)
				REG_WIDTH:     width_q     <= pwdata[DIM_W-1:0];
				REG_HEIGHT:    height_q    <= pwdata[DIM_W-1:0];
				REG_MARGIN:    margin_q    <= pwdata[MARGIN_W-1:0];
				REG_MIN_COUNT: min_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WIDTH:     prdata = DATA_W'(width_q);
			REG_HEIGHT:    prdata = DATA_W'(height_q);
			REG_MARGIN:    prdata = DATA_W'(margin_q);
			REG_MIN_COUNT: prdata = DATA_W'(min_count_q);
			default:       prdata = '0;
		endcase
	end

	// Frame geometry: zero reads as one, oversize saturates.
	always_comb begin
		if (width_q == '0) begin
			w_eff = dim_t'(1);
		end else if (width_q > MAX_WIDTH) begin
			w_eff = MAX_WIDTH;
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = dim_t'(1);
		end else if (height_q > MAX_HEIGHT) begin
			h_eff = MAX_HEIGHT;
		end else begin
			h_eff = height_q;
		end
		step = ((w_eff >> STEP_SHIFT) > STEP_CAP) ? STEP_CAP : (w_eff >> STEP_SHIFT);
		for (int k = 0; k < NUM_SPLITS; k++) begin
			lo_end_c[k]   = (w_eff >> 1) - dim_t'(step * dim_t'(k + 1));
			mid_end_c[k]  = lo_end_c[k] + dim_t'((step * dim_t'(k + 1)) << 1);
			rt_start_c[k] = w_eff - lo_end_c[k];
		end
	end

	always_ff @(posedge clk) begin
		lo_end_q   <= lo_end_c;
		mid_end_q  <= mid_end_c;
		rt_start_q <= rt_start_c;
	end

	// Raster position and input handshake
	assign col_wrap  = ({1'b0, col_q} + dim_t'(1)) >= w_eff;
	assign is_last   = col_wrap && (({1'b0, row_q} + dim_t'(1)) >= h_eff);
	assign pix_ready = !(is_last && (dec_busy || (valid_s1 && last_s1)));
	assign accept    = pix_valid && pix_ready;
	assign is_red    = ({1'b0, red} > ({1'b0, green} + {1'b0, margin_q}))
		&& ({1'b0, red} > ({1'b0, blue} + {1'b0, margin_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (dim_wr) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= is_last ? '0 : row_q + col_t'(1);
				end else begin
					col_q <= col_q + col_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1  <= red;
			hit_s1  <= is_red;
			x_s1    <= col_q;
			last_s1 <= is_last;
		end
	end

	// Strip membership and accumulation
	assign x_ext = {1'b0, x_s1};

	always_comb begin
		for (int k = 0; k < NUM_SPLITS; k++) begin
			in_strip[k*NUM_STRIPS + STRIP_LEFT]  = x_ext < lo_end_q[k];
			in_strip[k*NUM_STRIPS + STRIP_MID]   = (x_ext >= lo_end_q[k])
				&& (x_ext < mid_end_q[k]);
			in_strip[k*NUM_STRIPS + STRIP_RIGHT] = (x_ext >= rt_start_q[k]);
		end
		for (int i = 0; i < NUM_ACC; i++) begin
			if (hit_s1 && in_strip[i]) begin
				sum_nx[i] = acc_sum_q[i] + sum_t'(red_s1);
				cnt_nx[i] = acc_cnt_q[i] + cnt_t'(1);
			end else begin
				sum_nx[i] = acc_sum_q[i];
				cnt_nx[i] = acc_cnt_q[i];
			end
		end
	end

	assign dec_load = valid_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ACC; i++) begin
				acc_sum_q[i] <= '0;
				acc_cnt_q[i] <= '0;
			end
		end else if (dim_wr || dec_load) begin
			// Frame end hands the totals to the decision engine; clear for the next, also on a width or height write.
			for (int i = 0; i < NUM_ACC; i++) begin
				acc_sum_q[i] <= '0;
				acc_cnt_q[i] <= '0;
			end
		end else if (valid_s1) begin
			acc_sum_q <= sum_nx;
			acc_cnt_q <= cnt_nx;
		end
	end

	rdsf_decide u_decide (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (dec_load),
		.sums              (sum_nx),
		.counts            (cnt_nx),
		.min_count         (min_count_q),
		.busy              (dec_busy),
		.res_valid         (res_valid),
		.res_ready         (res_ready),
		.narrow_split_code (narrow_split_code),
		.medium_split_code (medium_split_code),
		.wide_split_code   (wide_split_code)
	);

endmodule
